// ----- design/hse_pkg.sv -----
// Shared types, constants and geometry helpers for the streaming Hamming encoder.
package hse_pkg;

  localparam int MAX_DATA_BITS_DEF = 64;
  localparam logic [6:0] DATA_BITS_MIN = 7'd8;
  localparam logic [6:0] DATA_BITS_RST = 7'd8;
  localparam int WORD_BYTES = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATA,
    ST_PAD,
    ST_EMIT,
    ST_FIN
  } enc_state_t;

  // One block bit on its way from the readout stage to the byte packer.
  typedef struct packed {
    logic vld;
    logic pow2;
    logic par;
  } emit_bit_t;

  // Packer status seen by the sequencer.
  typedef struct packed {
    logic hold;
    logic close_done;
  } pack_stat_t;

  // Smallest parity count r with 2^r >= k + r + 1.
  function automatic logic [2:0] calc_r(input logic [6:0] k);
    logic [2:0] r;
    r = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if ((9'd1 << i) >= 9'(k) + 9'(i) + 9'd1) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  // Bits needed for a block position 1..n at the largest block size.
  function automatic int pos_w(input int maxk);
    int n_max;
    n_max = maxk + int'(calc_r(7'(maxk)));
    return $clog2(n_max + 1);
  endfunction

  // Bits needed for a container length of up to 8 * n.
  function automatic int cont_w(input int maxk);
    int n_max;
    n_max = maxk + int'(calc_r(7'(maxk)));
    return $clog2(8 * n_max + 1);
  endfunction

endpackage

// ----- design/hse_store.sv -----
// Single-bit block store: one write port and one registered read port.
module hse_store
  import hse_pkg::*;
#(
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic              wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic              rdata
);

  logic mem [2**ADDR_W];

  // Write and registered read; the read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/hse_ctrl.sv -----
// Position sequencer: walks block positions bit by bit and reads finished blocks out.
module hse_ctrl
  import hse_pkg::*;
#(
  parameter int MAX_DATA_BITS = MAX_DATA_BITS_DEF,
  localparam int PW = pos_w(MAX_DATA_BITS),
  localparam int CW = cont_w(MAX_DATA_BITS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_wdata,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  input  logic          is_final,
  output logic          mem_we,
  output logic [PW-1:0] mem_waddr,
  output logic          mem_wdata,
  output logic          mem_re,
  output logic [PW-1:0] mem_raddr,
  output emit_bit_t     stg,
  output logic          close,
  input  pack_stat_t    stat
);

  // Container length lcm(n, 8) from the low bits of n.
  function automatic logic [CW-1:0] csize_of(input logic [PW-1:0] nv);
    logic [CW-1:0] c;
    if (nv[0]) begin
      c = CW'(nv) << 3;
    end else if (nv[1]) begin
      c = CW'(nv) << 2;
    end else if (nv[2]) begin
      c = CW'(nv) << 1;
    end else begin
      c = CW'(nv);
    end
    return c;
  endfunction

  localparam logic [PW-1:0] RST_N =
    PW'(int'(DATA_BITS_RST) + int'(calc_r(DATA_BITS_RST)));
  localparam logic [CW-1:0] RST_CSIZE = csize_of(RST_N);
  localparam logic [6:0] MAXK = 7'(MAX_DATA_BITS);

  enc_state_t    state, state_next;
  logic [PW-1:0] n, blk_pos, par_acc, par_sh, emit_pos, par_upd;
  logic [CW-1:0] csize, cont_pos, cont_next;
  logic [3:0]    bits_left, bits_after;
  logic [7:0]    data_sr;
  logic          fin;
  logic          adv, in_acc, walking, take_bit, pos_pow2, blk_end, emit_pow2, emit_end;
  logic [6:0]    k_eff;
  logic [2:0]    r_eff;
  logic [PW-1:0] n_new;

  // Geometry of a newly written block size, with the size clamped to range.
  always_comb begin
    if (cfg_wdata < DATA_BITS_MIN) begin
      k_eff = DATA_BITS_MIN;
    end else if (cfg_wdata > MAXK) begin
      k_eff = MAXK;
    end else begin
      k_eff = cfg_wdata;
    end
    r_eff = calc_r(k_eff);
    n_new = PW'(8'(k_eff) + 8'(r_eff));
  end

  // Per-position decode.
  assign adv       = !stat.hold;
  assign in_acc    = in_valid && !in_stall;
  assign walking   = (state == ST_DATA) || (state == ST_PAD);
  assign pos_pow2  = (blk_pos & (blk_pos - 1'b1)) == '0;
  assign blk_end   = blk_pos == n;
  assign take_bit  = (state == ST_DATA) && !pos_pow2;
  assign cont_next = (cont_pos + 1'b1 == csize) ? '0 : cont_pos + 1'b1;
  assign bits_after = take_bit ? bits_left - 4'd1 : bits_left;
  assign par_upd   = (take_bit && data_sr[0]) ? (par_acc ^ blk_pos) : par_acc;
  assign emit_pow2 = (emit_pos & (emit_pos - 1'b1)) == '0;
  assign emit_end  = emit_pos == n;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_DATA;
        end
      end
      ST_DATA: begin
        if (blk_end) begin
          state_next = ST_EMIT;
        end else if (bits_after == 4'd0) begin
          state_next = (fin && cont_next != '0) ? ST_PAD : ST_FIN;
        end
      end
      ST_PAD: begin
        if (blk_end) begin
          state_next = ST_EMIT;
        end else if (cont_next == '0) begin
          state_next = ST_FIN;
        end
      end
      ST_EMIT: begin
        if (emit_end) begin
          if (bits_left != 4'd0) begin
            state_next = ST_DATA;
          end else if (fin && cont_pos != '0) begin
            state_next = ST_PAD;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (stat.close_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    close     = 1'b0;
    mem_waddr = blk_pos;
    mem_wdata = take_bit && data_sr[0];
    mem_raddr = emit_pos;
    unique case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_DATA, ST_PAD: mem_we = adv;
      ST_EMIT: mem_re = adv;
      ST_FIN: close = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      n         <= RST_N;
      csize     <= RST_CSIZE;
      blk_pos   <= PW'(1);
      par_acc   <= '0;
      cont_pos  <= '0;
      bits_left <= 4'd0;
      stg       <= '0;
    end else begin
      if (adv) begin
        state   <= state_next;
        stg.vld <= (state == ST_EMIT);
        stg.pow2 <= emit_pow2;
        stg.par  <= par_sh[0];
      end
      if (cfg_we) begin
        n        <= n_new;
        csize    <= csize_of(n_new);
        blk_pos  <= PW'(1);
        par_acc  <= '0;
        cont_pos <= '0;
      end else if (adv) begin
        if (in_acc) begin
          bits_left <= 4'd8;
        end
        if (walking) begin
          blk_pos   <= blk_end ? PW'(1) : blk_pos + 1'b1;
          cont_pos  <= cont_next;
          bits_left <= bits_after;
          par_acc   <= blk_end ? '0 : par_upd;
        end
      end
    end
  end

  // Data registers: source shift register and readout counters.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (in_acc) begin
        data_sr <= in_byte;
        fin     <= is_final;
      end
      if (take_bit) begin
        data_sr <= {1'b0, data_sr[7:1]};
      end
      if (walking && blk_end) begin
        par_sh   <= par_upd;
        emit_pos <= PW'(1);
      end
      if (state == ST_EMIT) begin
        emit_pos <= emit_pos + 1'b1;
        if (emit_pow2) begin
          par_sh <= par_sh >> 1;
        end
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    blk_pos != '0 && blk_pos <= n)
    else $error("block position outside 1..n");

  a_cont_range: assert property (@(posedge clk) disable iff (rst)
    cont_pos < csize)
    else $error("container position past container length");

  a_data_bits: assert property (@(posedge clk) disable iff (rst)
    state == ST_DATA |-> bits_left != 4'd0)
    else $error("data walk with no source bits left");

endmodule

// ----- design/hse_pack.sv -----
// Byte packer: shifts block bits into bytes and gathers bytes into result words.
module hse_pack
  import hse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        clr,
  input  emit_bit_t   stg,
  input  logic        rd_bit,
  input  logic        close,
  output pack_stat_t  stat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bytes,
  output logic [3:0]  byte_count,
  output logic        last_of_run
);

  localparam logic [3:0] FULL = 4'(WORD_BYTES);

  logic [7:0]  pend, new_byte;
  logic [2:0]  pend_cnt;
  logic [63:0] word;
  logic [3:0]  word_cnt;
  logic        bit_v, out_free, cons, byte_done, spill, fin_load;

  // Bit selection and handshake decode.
  assign bit_v     = stg.pow2 ? stg.par : rd_bit;
  assign new_byte  = {bit_v, pend[7:1]};
  assign out_free  = !out_valid || !out_stall;
  assign stat.hold = stg.vld && pend_cnt == 3'd7 && word_cnt == FULL && !out_free;
  assign stat.close_done = close && !stg.vld && (word_cnt == 4'd0 || out_free);
  assign cons      = stg.vld && !stat.hold;
  assign byte_done = cons && pend_cnt == 3'd7;
  assign spill     = byte_done && word_cnt == FULL;
  assign fin_load  = stat.close_done && word_cnt != 4'd0;

  // Counters, gathering word and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt  <= 3'd0;
      word_cnt  <= 4'd0;
      word      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (clr) begin
        pend_cnt <= 3'd0;
      end else if (cons) begin
        pend_cnt <= pend_cnt + 3'd1;
      end
      if (spill) begin
        word_cnt <= 4'd1;
        word     <= 64'(new_byte);
      end else if (byte_done) begin
        word_cnt <= word_cnt + 4'd1;
        word[{word_cnt[2:0], 3'b000} +: 8] <= new_byte;
      end else if (fin_load) begin
        word_cnt <= 4'd0;
        word     <= '0;
      end
      if (spill || fin_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Bit shift register and output payload.
  always_ff @(posedge clk) begin
    if (cons) begin
      pend <= new_byte;
    end
    if (spill) begin
      out_bytes   <= word;
      byte_count  <= FULL;
      last_of_run <= 1'b0;
    end else if (fin_load) begin
      out_bytes   <= word;
      byte_count  <= word_cnt;
      last_of_run <= 1'b1;
    end
  end

  a_out_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_count != 4'd0 && byte_count <= FULL)
    else $error("result byte count out of range");

  a_word_count: assert property (@(posedge clk) disable iff (rst)
    word_cnt <= FULL)
    else $error("gathering word overfilled");

  a_close_last: assert property (@(posedge clk) disable iff (rst)
    fin_load |=> out_valid && last_of_run)
    else $error("closing word not presented as last result");

endmodule

// ----- design/hamming_stream_encoder.sv -----
// Top level of the streaming Hamming encoder: sequencer, block store and byte packer.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_stall   in_byte, is_final
//   output    out        out_valid / out_stall out_bytes, byte_count, last_of_run
//   config    in         cfg_we                cfg_wdata (data_bits)
//
// An item is accepted in idle. The sequencer then walks the block positions (the eight
// data bits, the parity positions passed and, on a final byte, the zero padding to the
// end of the container), reads each finished block out bit by bit through the single
// read port of the block store, and closes the result word.
// Reset is synchronous; the block store is not cleared and needs no clearing pass.
// Results wait in the output register while the next request is accepted; the engine
// freezes while that register is still taken and either a ninth byte is ready or the
// closing word of the request must be loaded.
module hamming_stream_encoder
  import hse_pkg::*;
#(
  parameter int MAX_DATA_BITS = MAX_DATA_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        is_final,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bytes,
  output logic [3:0]  byte_count,
  output logic        last_of_run
);

  localparam int PW = pos_w(MAX_DATA_BITS);

  logic          mem_we, mem_wdata, mem_re, rd_bit, close;
  logic [PW-1:0] mem_waddr, mem_raddr;
  emit_bit_t     stg;
  pack_stat_t    stat;

  hse_ctrl #(
    .MAX_DATA_BITS(MAX_DATA_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .is_final  (is_final),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .stg       (stg),
    .close     (close),
    .stat      (stat)
  );

  hse_store #(
    .ADDR_W(PW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_bit)
  );

  hse_pack u_pack (
    .clk         (clk),
    .rst         (rst),
    .clr         (cfg_we),
    .stg         (stg),
    .rd_bit      (rd_bit),
    .close       (close),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_bytes   (out_bytes),
    .byte_count  (byte_count),
    .last_of_run (last_of_run)
  );

endmodule

// ----- tb/hse_result_checker.sv -----
// Channel monitor, encoder predictor and result comparison for the streaming Hamming encoder.
`timescale 1ns / 1ps

module hse_result_checker
  import hse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        is_final,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_bytes,
  input  logic [3:0]  byte_count,
  input  logic        last_of_run,
  output int          fail_count,
  output int          words_due
);

  // One expected result word.
  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        last;
  } coded_word_t;

  coded_word_t coded_words_q [$];

  // Predicted encoder state.
  logic        blk_bits [128];
  logic [6:0]  data_bits_reg;
  logic [6:0]  par_acc;
  logic [6:0]  blk_pos;
  logic [9:0]  cont_pos;
  logic [7:0]  pend_byte;
  logic [2:0]  pend_cnt;
  logic [7:0]  item_bytes [$];

  initial begin
    fail_count = 0;
    words_due = 0;
    data_bits_reg = DATA_BITS_RST;
    foreach (blk_bits[i]) blk_bits[i] = 1'b0;
  end

  // Drops any partly built block, container and byte.
  function automatic void clear_stream();
    par_acc = '0;
    blk_pos = 7'd1;
    cont_pos = '0;
    pend_byte = '0;
    pend_cnt = '0;
  endfunction

  function automatic bit is_pow2(int p);
    return p != 0 && (p & (p - 1)) == 0;
  endfunction

  // Packs one code bit, least significant first, and collects finished bytes.
  function automatic void pack_bit(logic b);
    pend_byte[pend_cnt] = b;
    if (pend_cnt == 3'd7) begin
      item_bytes.push_back(pend_byte);
      pend_byte = '0;
    end
    pend_cnt = pend_cnt + 3'd1;
  endfunction

  // Reads out a finished block, position 1 first, parity at powers of two.
  function automatic void emit_block(int n);
    int j;
    for (int p = 1; p <= n; p++) begin
      if (is_pow2(p)) begin
        j = $clog2(p);
        pack_bit(par_acc[j]);
      end else begin
        pack_bit(blk_bits[p % 128]);
      end
    end
  endfunction

  // Fills one block position; returns 1 when a data bit was taken.
  function automatic bit walk_position(bit has_data, logic b, int n, int csize);
    int p;
    bit used;
    p = blk_pos;
    used = 1'b0;
    if (is_pow2(p) || !has_data) begin
      blk_bits[p % 128] = 1'b0;
    end else begin
      blk_bits[p % 128] = b;
      if (b) par_acc = par_acc ^ 7'(p);
      used = 1'b1;
    end
    if (p + 1 >= n + 1) begin
      emit_block(n);
      blk_pos = 7'd1;
      par_acc = '0;
    end else begin
      blk_pos = 7'(p + 1);
    end
    if (int'(cont_pos) + 1 >= csize) cont_pos = '0;
    else cont_pos = cont_pos + 10'd1;
    return used;
  endfunction

  // Encodes one accepted request and queues the result words it makes.
  function automatic void encode_item(logic [7:0] b, logic fin);
    int k, r, n, g, csize, used, nwords, cnt;
    coded_word_t w;
    k = data_bits_reg;
    if (k < DATA_BITS_MIN) k = DATA_BITS_MIN;
    if (k > MAX_DATA_BITS_DEF) k = MAX_DATA_BITS_DEF;
    r = 0;
    while ((1 << r) < k + r + 1) r++;
    n = k + r;
    g = (n % 8 == 0) ? 8 : (n % 4 == 0) ? 4 : (n % 2 == 0) ? 2 : 1;
    csize = n * 8 / g;

    item_bytes.delete();
    used = 0;
    while (used < 8) begin
      if (walk_position(1'b1, b[used], n, csize)) used++;
    end
    // The last byte pads with zero data bits to the end of the container.
    if (fin) begin
      while (cont_pos != 0) void'(walk_position(1'b0, 1'b0, n, csize));
    end

    nwords = (item_bytes.size() + 7) / 8;
    for (int i = 0; i < nwords; i++) begin
      cnt = item_bytes.size() - i * 8;
      if (cnt > 8) cnt = 8;
      w = '0;
      for (int j = 0; j < cnt; j++) w.bytes[j * 8 +: 8] = item_bytes[i * 8 + j];
      w.count = 4'(cnt);
      w.last = (i + 1 == nwords);
      coded_words_q.push_back(w);
    end
  endfunction

  // Compares one accepted result with the oldest expected word.
  function automatic void check_word();
    coded_word_t w;
    if (coded_words_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h/%0d/%b",
               $time, out_bytes, byte_count, last_of_run);
      fail_count++;
      return;
    end
    w = coded_words_q.pop_front();
    if (out_bytes !== w.bytes) begin
      $display("%0t: out_bytes mismatch, expected %h, actual %h", $time, w.bytes, out_bytes);
      fail_count++;
    end
    if (byte_count !== w.count) begin
      $display("%0t: byte_count mismatch, expected %0d, actual %0d",
               $time, w.count, byte_count);
      fail_count++;
    end
    if (last_of_run !== w.last) begin
      $display("%0t: last_of_run mismatch, expected %b, actual %b",
               $time, w.last, last_of_run);
      fail_count++;
    end
  endfunction

  // Samples all three channels at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      data_bits_reg = DATA_BITS_RST;
      clear_stream();
      coded_words_q.delete();
    end else begin
      if (cfg_we) begin
        data_bits_reg = cfg_wdata;
        clear_stream();
      end
      if (out_valid && !out_stall) check_word();
      if (in_valid && !in_stall) encode_item(in_byte, is_final);
    end
    words_due <= coded_words_q.size();
  end

endmodule

// ----- tb/tb_hamming_stream_encoder.sv -----
// Top of the streaming Hamming encoder testbench: clock, reset, request traffic and verdict.
`timescale 1ns / 1ps

module tb_hamming_stream_encoder;

  localparam int CLK_PERIOD      = 10;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES   = 2000;
  localparam int HOLD_CYCLES     = 800;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 10;
  localparam int HOLD_PHASE      = 2;
  localparam int PAUSE_PHASE     = 5;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        is_final;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic        last_of_run;

  int fail_count;
  int words_due;
  int cycle_count;
  int idle_pct;
  int stall_pct;
  int hold_reqs;
  int holds_served;

  always #(CLK_PERIOD / 2) clk = ~clk;

  hamming_stream_encoder dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .is_final    (is_final),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_bytes   (out_bytes),
    .byte_count  (byte_count),
    .last_of_run (last_of_run)
  );

  hse_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .is_final    (is_final),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_bytes   (out_bytes),
    .byte_count  (byte_count),
    .last_of_run (last_of_run),
    .fail_count  (fail_count),
    .words_due   (words_due)
  );

  // Block size used in each phase; the extremes and out-of-range values are included.
  function automatic logic [6:0] phase_data_bits(int ph);
    case (ph)
      0:       return 7'd0;
      1:       return 7'd12;
      2:       return 7'd16;
      3:       return 7'd127;
      4:       return 7'd24;
      5:       return 7'd32;
      6:       return 7'd48;
      7:       return 7'd7;
      8:       return 7'd64;
      9:       return 7'd65;
      10:      return 7'd10;
      default: return 7'd8;
    endcase
  endfunction

  // Offers one request and holds it until it is taken.
  task automatic send_request(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    is_final <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering and waits until every expected result is back, then lets the
  // engine finish any walk that makes no result.
  task automatic wait_quiet(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_data_bits(input logic [6:0] v);
    wait_quiet(SETTLE_CYCLES);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_served) begin
        holds_served = hold_reqs;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Cycle counter that ends a hung run.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] b;
    logic       fin;
    int         run_left;
    int         mode;

    idle_pct = 0;
    holds_served = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_byte <= '0;
    is_final <= 1'b0;
    stall_pct <= 0;
    hold_reqs <= 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset block size: byte extremes, single bits,
    // all-ones as a last byte, a run right after a last byte, and partial data
    // left behind for the next register write to drop.
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'h01, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(8'h55, 1'b0);
    send_request(8'hAA, 1'b1);
    send_request(8'hFF, 1'b1);
    send_request(8'h00, 1'b1);
    send_request(8'hFF, 1'b0);
    send_request(8'h7E, 1'b0);

    // Random phases, each with its own block size and idling pattern.
    run_left = 0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_data_bits(phase_data_bits(ph));
      mode = ph % 4;
      idle_pct = (mode == 1) ? 59 : (mode == 3) ? 22 : 0;
      stall_pct <= (mode == 2) ? 59 : (mode == 3) ? 22 : 0;
      if (ph == HOLD_PHASE) hold_reqs <= hold_reqs + 1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == PAUSE_PHASE && i == ITEMS_PER_PHASE / 2) wait_quiet(0);
        if (run_left == 0) run_left = $urandom_range(1, 8);
        run_left--;
        fin = (run_left == 0);
        // Now and then a stream is cut short.
        if (!fin && $urandom_range(99) < 8) begin
          fin = 1'b1;
          run_left = 0;
        end
        case ($urandom_range(9))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom);
        endcase
        send_request(b, fin);
      end
    end

    wait_quiet(SETTLE_CYCLES);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/hse_pkg.sv
design/hse_store.sv
design/hse_ctrl.sv
design/hse_pack.sv
design/hamming_stream_encoder.sv
tb/hse_result_checker.sv
tb/tb_hamming_stream_encoder.sv
